@@ rtl/qrs_pkg.sv @@
package qrs_pkg;

  localparam int COEFF_W  = 16;
  localparam int FRAC_W   = 16;
  localparam int DISC_W   = 34;
  localparam int ROOT_W   = 33;
  // Radicand is the discriminant shifted up by two fraction widths.
  localparam int RAD_W    = DISC_W + 2 * FRAC_W;
  localparam int SQ_STEPS = RAD_W / 2;
  localparam int SREM_W   = ROOT_W + 2;
  localparam int NB_W     = COEFF_W + 1 + FRAC_W;
  localparam int NUM_W    = NB_W + 1;
  localparam int MAG_W    = NUM_W - 1;
  localparam int DEN_W    = COEFF_W + 1;
  localparam int DIV_STEPS = MAG_W;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [1:0] {
    ST_TWO    = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_NONE   = 2'd2,
    ST_AZERO  = 2'd3
  } status_t;

  // Sideband that travels alongside the arithmetic through every cell.
  typedef struct packed {
    logic              valid;
    logic              a_zero;
    logic              a_neg;
    logic [DISC_W-1:0] disc;
    logic [NB_W-1:0]   nb;
    logic [DEN_W-1:0]  den;
    logic [1:0]        q_neg;
  } meta_t;

endpackage

@@ rtl/qrs_sqrt_cell.sv @@
module qrs_sqrt_cell
  import qrs_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  meta_t             meta_i,
  input  logic [SREM_W-1:0] rem_i,
  input  logic [ROOT_W-1:0] root_i,
  output meta_t             meta_o,
  output logic [SREM_W-1:0] rem_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int HI = RAD_W - 1 - 2 * IDX;

  meta_t             meta_r;
  logic [SREM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [RAD_W-1:0]  rad;
  logic [SREM_W+1:0] work;
  logic [SREM_W+1:0] trial;

  // One result bit per cell: bring down the next pair and try to subtract.
  always_comb begin
    rad   = {meta_i.disc, {(2 * FRAC_W){1'b0}}};
    work  = {rem_i, rad[HI -: 2]};
    trial = {2'b00, root_i, 2'b01};
    if (work >= trial) begin
      rem_nxt  = SREM_W'(work - trial);
      root_nxt = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = SREM_W'(work);
      root_nxt = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
    end else if (en) begin
      meta_r <= meta_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign meta_o = meta_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

@@ rtl/qrs_div_cell.sv @@
module qrs_div_cell
  import qrs_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  meta_t                 meta_i,
  input  logic [1:0][DEN_W-1:0] rem_i,
  input  logic [1:0][MAG_W-1:0] num_i,
  input  logic [1:0][MAG_W-1:0] q_i,
  output meta_t                 meta_o,
  output logic [1:0][DEN_W-1:0] rem_o,
  output logic [1:0][MAG_W-1:0] num_o,
  output logic [1:0][MAG_W-1:0] q_o
);

  localparam int BIT = MAG_W - 1 - IDX;

  meta_t                 meta_r;
  logic [1:0][DEN_W-1:0] rem_r, rem_nxt;
  logic [1:0][MAG_W-1:0] num_r;
  logic [1:0][MAG_W-1:0] q_r, q_nxt;
  logic [1:0][DEN_W:0]   work;

  // Restoring division, one quotient bit per cell for both roots.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      work[l] = {rem_i[l], num_i[l][BIT]};
      if (work[l] >= {1'b0, meta_i.den}) begin
        rem_nxt[l] = DEN_W'(work[l] - {1'b0, meta_i.den});
        q_nxt[l]   = {q_i[l][MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt[l] = DEN_W'(work[l]);
        q_nxt[l]   = {q_i[l][MAG_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
    end else if (en) begin
      meta_r <= meta_i;
      rem_r  <= rem_nxt;
      num_r  <= num_i;
      q_r    <= q_nxt;
    end
  end

  assign meta_o = meta_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign q_o    = q_r;

endmodule

@@ rtl/quadratic_root_solver_unit.sv @@
// Real roots of a*x^2 + b*x + c = 0 for a stream of coefficient sets.
//
// Input channel (in_*): one transaction carries coeff_a, coeff_b and coeff_c as
// signed 16-bit integers. Output channel (out_*): one transaction per input
// transaction, in order, with the exact discriminant b*b - 4ac, the two roots
// in signed Q17.16 (truncated toward zero), a status code and a flag that is
// set when the discriminant is zero or positive. When a is zero or the
// discriminant is negative, both roots read as zero.
//
// Throughput is one transaction per cycle while no stall holds the pipeline. From
// input acceptance to the result appearing on out_tvalid, a transaction passes an
// input register, a multiply stage, a discriminant stage, a row of 33 square-root
// cells (one root bit each), a numerator stage, a row of 33 divider cells (one
// quotient bit each, both roots side by side) and the output register.
//
// Reset clears every valid flag, so the pipeline and the output are empty.
// When the receiver stalls, the output register holds its transaction and a
// one-entry skid register catches the next one; in_tready then drops and the
// whole pipeline freezes until the skid register drains.
module quadratic_root_solver_unit
  import qrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // coeff_a [15:0], coeff_b [31:16], coeff_c [47:32]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // discriminant [33:0], root_plus [66:34], root_minus [99:67], zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status [1:0], has_roots [2]
  output logic [2:0]            out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  // The whole pipeline advances together while the skid register is empty.
  logic en;

  // Input register.
  logic                      s0_v_r;
  logic signed [COEFF_W-1:0] s0_a_r, s0_b_r, s0_c_r;

  // Product stage.
  logic                        s1_v_r;
  logic signed [COEFF_W-1:0]   s1_a_r, s1_b_r;
  logic signed [2*COEFF_W-1:0] s1_bb_r, s1_ac_r;

  // Discriminant stage feeds the square-root row.
  meta_t             sq_meta [0:SQ_STEPS];
  logic [SREM_W-1:0] sq_rem  [0:SQ_STEPS];
  logic [ROOT_W-1:0] sq_root [0:SQ_STEPS];
  meta_t             s2_meta_nxt;

  // Numerator stage feeds the divider row.
  meta_t                 dv_meta [0:DIV_STEPS];
  logic [1:0][DEN_W-1:0] dv_rem  [0:DIV_STEPS];
  logic [1:0][MAG_W-1:0] dv_num  [0:DIV_STEPS];
  logic [1:0][MAG_W-1:0] dv_q    [0:DIV_STEPS];
  meta_t                 s3_meta_nxt;
  logic [1:0][MAG_W-1:0] s3_num_nxt;
  logic [NUM_W-1:0]      num_p, num_m;

  // Result formatting and output buffering.
  meta_t                 fin;
  logic [1:0][ROOT_W-1:0] fin_root;
  status_t               fin_status;
  logic [OUT_DATA_W-1:0] fin_data;
  logic [2:0]            fin_user;
  logic                  out_v_r, skid_v_r, take;
  logic [OUT_DATA_W-1:0] out_data_r, skid_data_r;
  logic [2:0]            out_user_r, skid_user_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r  <= in_tvalid;
      s0_a_r  <= in_tdata[COEFF_W-1:0];
      s0_b_r  <= in_tdata[2*COEFF_W-1:COEFF_W];
      s0_c_r  <= in_tdata[3*COEFF_W-1:2*COEFF_W];
      s1_v_r  <= s0_v_r;
      s1_a_r  <= s0_a_r;
      s1_b_r  <= s0_b_r;
      s1_bb_r <= s0_b_r * s0_b_r;
      s1_ac_r <= s0_a_r * s0_c_r;
    end
  end

  // b*b - 4ac fits 34 bits exactly; -b scaled by 2^16 and |2a| are prepared here
  // for the divider row.
  always_comb begin
    logic [COEFF_W:0] a_ext, b_ext, abs_a, neg_b;
    a_ext = {s1_a_r[COEFF_W-1], s1_a_r};
    b_ext = {s1_b_r[COEFF_W-1], s1_b_r};
    abs_a = a_ext[COEFF_W] ? (~a_ext + 1'b1) : a_ext;
    neg_b = ~b_ext + 1'b1;
    s2_meta_nxt.valid  = s1_v_r;
    s2_meta_nxt.a_zero = (s1_a_r == '0);
    s2_meta_nxt.a_neg  = s1_a_r[COEFF_W-1];
    s2_meta_nxt.disc   = {{(DISC_W-2*COEFF_W){s1_bb_r[2*COEFF_W-1]}}, s1_bb_r}
                       - {s1_ac_r, 2'b00};
    s2_meta_nxt.nb     = {neg_b, {FRAC_W{1'b0}}};
    s2_meta_nxt.den    = {abs_a[COEFF_W-1:0], 1'b0};
    s2_meta_nxt.q_neg  = 2'b00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_meta[0].valid <= 1'b0;
    end else if (en) begin
      sq_meta[0] <= s2_meta_nxt;
    end
  end

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    qrs_sqrt_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .meta_i (sq_meta[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .meta_o (sq_meta[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  // Numerators -b*2^16 +/- sqrt, split into magnitude and quotient sign.
  always_comb begin
    num_p = {sq_meta[SQ_STEPS].nb[NB_W-1], sq_meta[SQ_STEPS].nb}
          + {1'b0, sq_root[SQ_STEPS]};
    num_m = {sq_meta[SQ_STEPS].nb[NB_W-1], sq_meta[SQ_STEPS].nb}
          - {1'b0, sq_root[SQ_STEPS]};
    s3_meta_nxt = sq_meta[SQ_STEPS];
    s3_meta_nxt.q_neg = {num_m[NUM_W-1] ^ sq_meta[SQ_STEPS].a_neg,
                         num_p[NUM_W-1] ^ sq_meta[SQ_STEPS].a_neg};
    s3_num_nxt[0] = MAG_W'(num_p[NUM_W-1] ? (~num_p + 1'b1) : num_p);
    s3_num_nxt[1] = MAG_W'(num_m[NUM_W-1] ? (~num_m + 1'b1) : num_m);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_meta[0].valid <= 1'b0;
    end else if (en) begin
      dv_meta[0] <= s3_meta_nxt;
      dv_num[0]  <= s3_num_nxt;
    end
  end

  assign dv_rem[0] = '0;
  assign dv_q[0]   = '0;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    qrs_div_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .meta_i (dv_meta[i]),
      .rem_i  (dv_rem[i]),
      .num_i  (dv_num[i]),
      .q_i    (dv_q[i]),
      .meta_o (dv_meta[i+1]),
      .rem_o  (dv_rem[i+1]),
      .num_o  (dv_num[i+1]),
      .q_o    (dv_q[i+1])
    );
  end

  // Apply quotient signs and the special cases, then pack the transaction.
  always_comb begin
    fin = dv_meta[DIV_STEPS];
    for (int l = 0; l < 2; l++) begin
      if (fin.a_zero || fin.disc[DISC_W-1]) begin
        fin_root[l] = '0;
      end else if (fin.q_neg[l]) begin
        fin_root[l] = ~dv_q[DIV_STEPS][l] + 1'b1;
      end else begin
        fin_root[l] = dv_q[DIV_STEPS][l];
      end
    end
    if (fin.a_zero) begin
      fin_status = ST_AZERO;
    end else if (fin.disc[DISC_W-1]) begin
      fin_status = ST_NONE;
    end else if (fin.disc == '0) begin
      fin_status = ST_DOUBLE;
    end else begin
      fin_status = ST_TWO;
    end
    fin_data = {{(OUT_DATA_W-DISC_W-2*ROOT_W){1'b0}}, fin_root[1], fin_root[0], fin.disc};
    fin_user = {!fin.disc[DISC_W-1], fin_status};
  end

  // Output register plus one skid entry.
  assign take = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take || !out_v_r) begin
        out_v_r    <= 1'b1;
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
        skid_v_r   <= 1'b0;
      end
    end else if (fin.valid) begin
      if (!out_v_r || take) begin
        out_v_r    <= 1'b1;
        out_data_r <= fin_data;
        out_user_r <= fin_user;
      end else begin
        skid_v_r    <= 1'b1;
        skid_data_r <= fin_data;
        skid_user_r <= fin_user;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while output register empty");

  a_flag_matches_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_user_r[2] == !out_data_r[DISC_W-1]))
    else $error("has_roots disagrees with discriminant sign");

  a_azero_roots: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_user_r[1:0] == ST_AZERO || out_user_r[1:0] == ST_NONE))
      |-> (out_data_r[DISC_W+2*ROOT_W-1:DISC_W] == '0))
    else $error("roots not cleared for degenerate or complex case");

endmodule
